// ===== sv/rau_pkg.sv =====
// Shared constants, codes and divider handshake types for the rational arithmetic unit.
package rau_pkg;

  localparam int unsigned NUM_W = 32;
  localparam int unsigned DEN_W = 31;
  localparam int unsigned OP_W  = 3;
  localparam int unsigned ST_W  = 2;

  // datapath width of the shared divider and of the working registers
  localparam int unsigned DW = 64;
  localparam int unsigned CW = $clog2(DW);

  localparam int unsigned DEF_WIDTH = 32;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_CMP = 3'd4;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_DIV0 = 2'd1;
  localparam logic [ST_W-1:0] ST_OVF  = 2'd2;

  // result magnitude bound never exceeds the output field range
  localparam logic [DW-1:0] LIM_CAP = 64'h0000_0000_7FFF_FFFF;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] dividend;
    logic [DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [DW-1:0] quo;
    logic [DW-1:0] rem;
  } div_rsp_t;

endpackage

// ===== sv/rau_in_if.sv =====
// Input channel of the rational arithmetic unit: operation and two rationals.
interface rau_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic signed [31:0] a_num;
  logic [30:0] a_den;
  logic signed [31:0] b_num;
  logic [30:0] b_den;

  modport source (output valid, output op, output a_num, output a_den,
                  output b_num, output b_den, input ready);
  modport sink   (input valid, input op, input a_num, input a_den,
                  input b_num, input b_den, output ready);
endinterface

// ===== sv/rau_out_if.sv =====
// Output channel of the rational arithmetic unit: reduced result, compare flags, status.
interface rau_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] res_num;
  logic [30:0] res_den;
  logic        is_less;
  logic        is_equal;
  logic [1:0]  status;

  modport source (output valid, output res_num, output res_den, output is_less,
                  output is_equal, output status, input ready);
  modport sink   (input valid, input res_num, input res_den, input is_less,
                  input is_equal, input status, output ready);
endinterface

// ===== sv/rau_divmod.sv =====
// Shared shift-subtract divider: aligns the divisor, then one quotient bit per cycle.
module rau_divmod
  import rau_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t div_req_i,
  output div_rsp_t div_rsp_o
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ALIGN = 2'd1;
  localparam logic [1:0] PH_SUB   = 2'd2;

  logic [1:0]    phase_q, phase_d;
  logic          done_q, done_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW:0]   diff;
  logic [DW-1:0] dvs_dbl;

  assign diff    = {1'b0, rem_q} - {1'b0, dvs_q};
  assign dvs_dbl = {dvs_q[DW-2:0], 1'b0};

  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    den_d   = den_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (div_req_i.start) begin
          rem_d   = div_req_i.dividend;
          dvs_d   = div_req_i.divisor;
          den_d   = div_req_i.divisor;
          quo_d   = '0;
          cnt_d   = '0;
          phase_d = PH_ALIGN;
        end
      end
      PH_ALIGN: begin
        // grow the divisor while it still fits under the remainder
        if (!dvs_q[DW-1] && (dvs_dbl <= rem_q)) begin
          dvs_d = dvs_dbl;
          cnt_d = cnt_q + CW'(1);
        end else begin
          phase_d = PH_SUB;
        end
      end
      PH_SUB: begin
        if (!diff[DW]) begin
          rem_d = diff[DW-1:0];
          quo_d = {quo_q[DW-2:0], 1'b1};
        end else begin
          quo_d = {quo_q[DW-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          phase_d = PH_IDLE;
          done_d  = 1'b1;
        end else begin
          dvs_d = {1'b0, dvs_q[DW-1:1]};
          cnt_d = cnt_q - CW'(1);
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    den_q <= den_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
  end

  assign div_rsp_o.busy = (phase_q != PH_IDLE);
  assign div_rsp_o.done = done_q;
  assign div_rsp_o.quo  = quo_q;
  assign div_rsp_o.rem  = rem_q;

  a_rem_below_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

  a_no_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_i.start |-> (phase_q == PH_IDLE))
    else $error("divider started while busy");

endmodule

// ===== sv/rau_mul.sv =====
// Registered 32 by 32 unsigned multiplier for the cross terms and products.
module rau_mul
  import rau_pkg::*;
(
  input  logic          clk_i,
  input  logic [31:0]   a_i,
  input  logic [31:0]   b_i,
  output logic [DW-1:0] prod_o
);

  logic [DW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= DW'(a_i) * DW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ===== sv/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: sequencer around a shared divider.
//
// Takes one item of two rationals (signed numerator, positive denominator) and an
// operation code, and returns one item: the result in lowest terms with the sign on
// the numerator and zero as 0/1, compare flags, and a status (ok, division by zero,
// overflow beyond the WIDTH bound, which is capped at 2^31-1). Both operands are
// reduced first; multiply and divide cross-reduce before multiplying; compare is an
// exact cross-multiplication. The block works on one item at a time and is ready
// again as soon as its result sits in the output register, even if that result has
// not been taken yet. The time per item depends on the data and is set by the shared
// shift-subtract divider, which serves every Euclid remainder step and every division
// by a gcd; it grows with the bit length of each quotient and with the number of
// remainder steps in each gcd. A zero denominator goes straight to the status
// without using the divider.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned WIDTH = DEF_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rau_in_if.sink    in_i,
  rau_out_if.source out_o
);

  // magnitude bound on reduced numerator and denominator
  localparam logic [DW-1:0] Lim = (WIDTH >= 32) ? LIM_CAP
                                                : ((DW'(1) << (WIDTH - 1)) - DW'(1));

  localparam int unsigned SW = 5;
  localparam logic [SW-1:0] S_IDLE   = 5'd0;
  localparam logic [SW-1:0] S_CHK    = 5'd1;
  localparam logic [SW-1:0] S_RED    = 5'd2;
  localparam logic [SW-1:0] S_RED_N  = 5'd3;
  localparam logic [SW-1:0] S_RED_NW = 5'd4;
  localparam logic [SW-1:0] S_RED_DW = 5'd5;
  localparam logic [SW-1:0] S_GCD    = 5'd6;
  localparam logic [SW-1:0] S_GWAIT  = 5'd7;
  localparam logic [SW-1:0] S_RA     = 5'd8;
  localparam logic [SW-1:0] S_RB     = 5'd9;
  localparam logic [SW-1:0] S_M1     = 5'd10;
  localparam logic [SW-1:0] S_M2     = 5'd11;
  localparam logic [SW-1:0] S_M3     = 5'd12;
  localparam logic [SW-1:0] S_M4     = 5'd13;
  localparam logic [SW-1:0] S_M5     = 5'd14;
  localparam logic [SW-1:0] S_P0     = 5'd15;
  localparam logic [SW-1:0] S_P1     = 5'd16;
  localparam logic [SW-1:0] S_P2     = 5'd17;
  localparam logic [SW-1:0] S_P3     = 5'd18;
  localparam logic [SW-1:0] S_P4     = 5'd19;
  localparam logic [SW-1:0] S_P5     = 5'd20;
  localparam logic [SW-1:0] S_P6     = 5'd21;
  localparam logic [SW-1:0] S_P7     = 5'd22;
  localparam logic [SW-1:0] S_P8     = 5'd23;
  localparam logic [SW-1:0] S_P9     = 5'd24;
  localparam logic [SW-1:0] S_FIN    = 5'd25;
  localparam logic [SW-1:0] S_PACK   = 5'd26;

  // sequencer control
  logic [SW-1:0] state_q, state_d;
  logic [SW-1:0] red_ret_q, red_ret_d;
  logic [SW-1:0] gcd_ret_q, gcd_ret_d;
  logic          gsel_q, gsel_d;

  // operands after sign split
  logic [OP_W-1:0] op_q, op_d;
  logic [31:0]     an_q, an_d;
  logic [31:0]     bn_q, bn_d;
  logic [DEN_W-1:0] ad_q, ad_d;
  logic [DEN_W-1:0] bd_q, bd_d;
  logic            an_neg_q, an_neg_d;
  logic            bn_neg_q, bn_neg_d;

  // working registers
  logic [DW-1:0] rn_q, rn_d;
  logic [DW-1:0] rd_q, rd_d;
  logic [DW-1:0] ga_q, ga_d;
  logic [DW-1:0] gb_q, gb_d;
  logic [DW-1:0] g_q, g_d;
  logic [31:0]   g1_q, g1_d;
  logic [31:0]   pn_q, pn_d;
  logic [31:0]   pd_q, pd_d;
  logic [31:0]   qn_q, qn_d;
  logic [31:0]   qd_q, qd_d;
  logic signed [DW-1:0] x_q, x_d;
  logic signed [DW-1:0] y_q, y_d;

  // result flags
  logic            rneg_q, rneg_d;
  logic            arith_q, arith_d;
  logic            less_q, less_d;
  logic            eq_q, eq_d;
  logic [ST_W-1:0] st_q, st_d;

  // output register
  logic             ovalid_q, ovalid_d;
  logic [NUM_W-1:0] onum_q, onum_d;
  logic [DEN_W-1:0] oden_q, oden_d;
  logic             oless_q, oless_d;
  logic             oeq_q, oeq_d;
  logic [ST_W-1:0]  ost_q, ost_d;

  // shared units
  div_req_t      div_req;
  div_rsp_t      div_rsp;
  logic [31:0]   mul_a, mul_b;
  logic [DW-1:0] prod;

  logic [31:0] qn_sel, qd_sel;
  logic        use_res;

  rau_divmod u_divmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .div_req_i (div_req),
    .div_rsp_o (div_rsp)
  );

  rau_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign in_i.ready = (state_q == S_IDLE);

  // multiplier operands by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_M1: begin
        mul_a = an_q;
        mul_b = {1'b0, bd_q};
      end
      S_M2: begin
        mul_a = bn_q;
        mul_b = {1'b0, ad_q};
      end
      S_M3: begin
        mul_a = {1'b0, ad_q};
        mul_b = {1'b0, bd_q};
      end
      S_P7: begin
        mul_a = pn_q;
        mul_b = qn_q;
      end
      S_P8: begin
        mul_a = pd_q;
        mul_b = qd_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divide swaps the second operand
  assign qn_sel = (op_q == OP_DIV) ? {1'b0, bd_q} : bn_q;
  assign qd_sel = (op_q == OP_DIV) ? bn_q : {1'b0, bd_q};

  assign use_res = (st_q == ST_OK) && arith_q;

  always_comb begin
    state_d   = state_q;
    red_ret_d = red_ret_q;
    gcd_ret_d = gcd_ret_q;
    gsel_d    = gsel_q;
    op_d      = op_q;
    an_d      = an_q;
    bn_d      = bn_q;
    ad_d      = ad_q;
    bd_d      = bd_q;
    an_neg_d  = an_neg_q;
    bn_neg_d  = bn_neg_q;
    rn_d      = rn_q;
    rd_d      = rd_q;
    ga_d      = ga_q;
    gb_d      = gb_q;
    g_d       = g_q;
    g1_d      = g1_q;
    pn_d      = pn_q;
    pd_d      = pd_q;
    qn_d      = qn_q;
    qd_d      = qd_q;
    x_d       = x_q;
    y_d       = y_q;
    rneg_d    = rneg_q;
    arith_d   = arith_q;
    less_d    = less_q;
    eq_d      = eq_q;
    st_d      = st_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    onum_d    = onum_q;
    oden_d    = oden_q;
    oless_d   = oless_q;
    oeq_d     = oeq_q;
    ost_d     = ost_q;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d     = in_i.op;
          an_neg_d = in_i.a_num[31];
          an_d     = in_i.a_num[31] ? (32'd0 - $unsigned(in_i.a_num)) : $unsigned(in_i.a_num);
          bn_neg_d = in_i.b_num[31];
          bn_d     = in_i.b_num[31] ? (32'd0 - $unsigned(in_i.b_num)) : $unsigned(in_i.b_num);
          ad_d     = in_i.a_den;
          bd_d     = in_i.b_den;
          st_d     = ST_OK;
          arith_d  = 1'b0;
          less_d   = 1'b0;
          eq_d     = 1'b0;
          rneg_d   = 1'b0;
          state_d  = S_CHK;
        end
      end
      S_CHK: begin
        if ((ad_q == '0) || (bd_q == '0)) begin
          st_d    = ST_DIV0;
          state_d = S_PACK;
        end else begin
          rn_d      = DW'(an_q);
          rd_d      = DW'(ad_q);
          red_ret_d = S_RA;
          state_d   = S_RED;
        end
      end
      // reduce rn/rd to lowest terms, then return
      S_RED: begin
        if (rn_q == '0) begin
          rd_d    = DW'(1);
          state_d = red_ret_q;
        end else begin
          ga_d      = rn_q;
          gb_d      = rd_q;
          gcd_ret_d = S_RED_N;
          state_d   = S_GCD;
        end
      end
      S_RED_N: begin
        div_req.start    = 1'b1;
        div_req.dividend = rn_q;
        div_req.divisor  = g_q;
        state_d          = S_RED_NW;
      end
      S_RED_NW: begin
        if (div_rsp.done) begin
          rn_d             = div_rsp.quo;
          div_req.start    = 1'b1;
          div_req.dividend = rd_q;
          div_req.divisor  = g_q;
          state_d          = S_RED_DW;
        end
      end
      S_RED_DW: begin
        if (div_rsp.done) begin
          rd_d    = div_rsp.quo;
          state_d = red_ret_q;
        end
      end
      // Euclid by remainders on ga/gb, result in g
      S_GCD: begin
        if ((ga_q == '0) || (gb_q == '0)) begin
          g_d     = ga_q | gb_q;
          state_d = gcd_ret_q;
        end else if (ga_q > gb_q) begin
          div_req.start    = 1'b1;
          div_req.dividend = ga_q;
          div_req.divisor  = gb_q;
          gsel_d           = 1'b0;
          state_d          = S_GWAIT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = gb_q;
          div_req.divisor  = ga_q;
          gsel_d           = 1'b1;
          state_d          = S_GWAIT;
        end
      end
      S_GWAIT: begin
        if (div_rsp.done) begin
          if (gsel_q) begin
            gb_d = div_rsp.rem;
          end else begin
            ga_d = div_rsp.rem;
          end
          state_d = S_GCD;
        end
      end
      S_RA: begin
        an_d      = rn_q[31:0];
        ad_d      = rd_q[DEN_W-1:0];
        an_neg_d  = an_neg_q && (rn_q != '0);
        rn_d      = DW'(bn_q);
        rd_d      = DW'(bd_q);
        red_ret_d = S_RB;
        state_d   = S_RED;
      end
      S_RB: begin
        bn_d     = rn_q[31:0];
        bd_d     = rd_q[DEN_W-1:0];
        bn_neg_d = bn_neg_q && (rn_q != '0);
        priority if ((op_q == OP_ADD) || (op_q == OP_SUB) || (op_q == OP_CMP)) begin
          state_d = S_M1;
        end else if ((op_q == OP_MUL) || (op_q == OP_DIV)) begin
          state_d = S_P0;
        end else begin
          state_d = S_PACK;
        end
      end
      // cross terms for add, subtract and compare
      S_M1: begin
        state_d = S_M2;
      end
      S_M2: begin
        x_d     = an_neg_q ? (DW'(0) - prod) : prod;
        state_d = S_M3;
      end
      S_M3: begin
        y_d     = bn_neg_q ? (DW'(0) - prod) : prod;
        state_d = S_M4;
      end
      S_M4: begin
        rd_d = prod;
        if (op_q == OP_CMP) begin
          less_d  = (x_q < y_q);
          eq_d    = (x_q == y_q);
          state_d = S_PACK;
        end else begin
          rn_d    = (op_q == OP_ADD) ? $unsigned(x_q + y_q) : $unsigned(x_q - y_q);
          state_d = S_M5;
        end
      end
      S_M5: begin
        rneg_d    = rn_q[DW-1];
        rn_d      = rn_q[DW-1] ? (DW'(0) - rn_q) : rn_q;
        arith_d   = 1'b1;
        red_ret_d = S_FIN;
        state_d   = S_RED;
      end
      // multiply and divide: cross-reduce, then multiply
      S_P0: begin
        if ((op_q == OP_DIV) && (bn_q == '0)) begin
          st_d    = ST_DIV0;
          state_d = S_PACK;
        end else begin
          pn_d      = an_q;
          pd_d      = {1'b0, ad_q};
          qn_d      = qn_sel;
          qd_d      = qd_sel;
          ga_d      = DW'(an_q);
          gb_d      = DW'(qd_sel);
          gcd_ret_d = S_P1;
          state_d   = S_GCD;
        end
      end
      S_P1: begin
        g1_d      = g_q[31:0];
        ga_d      = DW'(qn_q);
        gb_d      = DW'(pd_q);
        gcd_ret_d = S_P2;
        state_d   = S_GCD;
      end
      S_P2: begin
        div_req.start    = 1'b1;
        div_req.dividend = DW'(pn_q);
        div_req.divisor  = DW'(g1_q);
        state_d          = S_P3;
      end
      S_P3: begin
        if (div_rsp.done) begin
          pn_d             = div_rsp.quo[31:0];
          div_req.start    = 1'b1;
          div_req.dividend = DW'(qd_q);
          div_req.divisor  = DW'(g1_q);
          state_d          = S_P4;
        end
      end
      S_P4: begin
        if (div_rsp.done) begin
          qd_d             = div_rsp.quo[31:0];
          div_req.start    = 1'b1;
          div_req.dividend = DW'(qn_q);
          div_req.divisor  = g_q;
          state_d          = S_P5;
        end
      end
      S_P5: begin
        if (div_rsp.done) begin
          qn_d             = div_rsp.quo[31:0];
          div_req.start    = 1'b1;
          div_req.dividend = DW'(pd_q);
          div_req.divisor  = g_q;
          state_d          = S_P6;
        end
      end
      S_P6: begin
        if (div_rsp.done) begin
          pd_d    = div_rsp.quo[31:0];
          state_d = S_P7;
        end
      end
      S_P7: begin
        state_d = S_P8;
      end
      S_P8: begin
        rn_d    = prod;
        state_d = S_P9;
      end
      S_P9: begin
        rd_d      = prod;
        rneg_d    = an_neg_q ^ bn_neg_q;
        arith_d   = 1'b1;
        red_ret_d = S_FIN;
        state_d   = S_RED;
      end
      S_FIN: begin
        rneg_d = rneg_q && (rn_q != '0);
        if ((rn_q > Lim) || (rd_q > Lim)) begin
          st_d = ST_OVF;
        end
        state_d = S_PACK;
      end
      // hand the item to the output register once it is free
      S_PACK: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          onum_d   = use_res ? (rneg_q ? (32'd0 - rn_q[31:0]) : rn_q[31:0]) : '0;
          oden_d   = use_res ? rd_q[DEN_W-1:0] : DEN_W'(1);
          oless_d  = (st_q == ST_OK) && less_q;
          oeq_d    = (st_q == ST_OK) && eq_q;
          ost_d    = st_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      red_ret_q <= S_IDLE;
      gcd_ret_q <= S_IDLE;
      gsel_q    <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      red_ret_q <= red_ret_d;
      gcd_ret_q <= gcd_ret_d;
      gsel_q    <= gsel_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    an_q     <= an_d;
    bn_q     <= bn_d;
    ad_q     <= ad_d;
    bd_q     <= bd_d;
    an_neg_q <= an_neg_d;
    bn_neg_q <= bn_neg_d;
    rn_q     <= rn_d;
    rd_q     <= rd_d;
    ga_q     <= ga_d;
    gb_q     <= gb_d;
    g_q      <= g_d;
    g1_q     <= g1_d;
    pn_q     <= pn_d;
    pd_q     <= pd_d;
    qn_q     <= qn_d;
    qd_q     <= qd_d;
    x_q      <= x_d;
    y_q      <= y_d;
    rneg_q   <= rneg_d;
    arith_q  <= arith_d;
    less_q   <= less_d;
    eq_q     <= eq_d;
    st_q     <= st_d;
    onum_q   <= onum_d;
    oden_q   <= oden_d;
    oless_q  <= oless_d;
    oeq_q    <= oeq_d;
    ost_q    <= ost_d;
  end

  assign out_o.valid    = ovalid_q;
  assign out_o.res_num  = $signed(onum_q);
  assign out_o.res_den  = oden_q;
  assign out_o.is_less  = oless_q;
  assign out_o.is_equal = oeq_q;
  assign out_o.status   = ost_q;

  a_err_zero_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status != ST_OK)) |->
      ((onum_q == '0) && (oden_q == DEN_W'(1)) && !oless_q && !oeq_q))
    else $error("error result not cleared to 0/1");

  a_den_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (oden_q != '0))
    else $error("result denominator is zero");

  a_idle_div_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  a_held_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(onum_q) && $stable(ost_q)))
    else $error("unaccepted result changed");

endmodule

// ===== sim/rational_arithmetic_unit_tb.sv =====
// Self-checking testbench for the rational arithmetic unit: directed rows, then random items.
module rational_arithmetic_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rau_pkg::*;

  // The unit runs with its default width; the predictor's bound follows it.
  localparam int unsigned MODEL_WIDTH = DEF_WIDTH;
  localparam logic [63:0] RES_LIM = (MODEL_WIDTH - 1 >= 31) ? LIM_CAP :
                                    ((64'd1 << (MODEL_WIDTH - 1)) - 64'd1);

  // Codes 5 to 7 carry no operation; the unit answers them with 0/1.
  localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  localparam logic [NUM_W-1:0] MAX_NUM = 32'h7FFF_FFFF;
  localparam logic [NUM_W-1:0] MIN_NUM = 32'h8000_0000;
  localparam logic [DEN_W-1:0] MAX_DEN = 31'h7FFF_FFFF;

  localparam int N_RANDOM     = 800;
  // Wait after the last result, to catch stray extras.
  localparam int DRAIN_CYCLES = 4000;
  // Overall cycle limit, after which the run stops as hung.
  localparam int CYCLE_LIMIT  = 20_000_000;
  localparam int IDLE_PCT     = 16;
  localparam int MAX_LINES    = 60;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [NUM_W-1:0] a_num;
    logic [DEN_W-1:0] a_den;
    logic [NUM_W-1:0] b_num;
    logic [DEN_W-1:0] b_den;
  } rat_op_t;

  typedef struct packed {
    logic [NUM_W-1:0] res_num;
    logic [DEN_W-1:0] res_den;
    logic             is_less;
    logic             is_equal;
    logic [ST_W-1:0]  status;
  } rat_res_t;

  // A directed row: operands, and a typed-in result where one is plain to see.
  typedef struct packed {
    logic     typed;
    rat_op_t  opnd;
    rat_res_t res;
  } stim_row_t;

  localparam rat_res_t R_ZERO = '{32'd0, 31'd1, 1'b0, 1'b0, ST_OK};
  localparam rat_res_t R_ONE  = '{32'd1, 31'd1, 1'b0, 1'b0, ST_OK};
  localparam rat_res_t R_LESS = '{32'd0, 31'd1, 1'b1, 1'b0, ST_OK};
  localparam rat_res_t R_EQ   = '{32'd0, 31'd1, 1'b0, 1'b1, ST_OK};
  localparam rat_res_t R_DIV0 = '{32'd0, 31'd1, 1'b0, 1'b0, ST_DIV0};
  localparam rat_res_t R_OVF  = '{32'd0, 31'd1, 1'b0, 1'b0, ST_OVF};
  localparam rat_res_t R_PRED = '{32'd0, 31'd0, 1'b0, 1'b0, ST_OK};

  localparam int N_DIRECTED = 25;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // zero plus zero comes back as 0/1
    '{1'b1, '{OP_ADD, 32'sd0, 31'd1, 32'sd0, 31'd1}, R_ZERO},
    '{1'b0, '{OP_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3}, R_PRED},
    // unreduced operand cancels to zero
    '{1'b1, '{OP_SUB, 32'sd1, 31'd2, 32'sd2, 31'd4}, R_ZERO},
    '{1'b0, '{OP_SUB, 32'sd1, 31'd3, 32'sd1, 31'd2}, R_PRED},
    // cross-reduction before the product
    '{1'b0, '{OP_MUL, 32'sd2, 31'd3, 32'sd9, 31'd4}, R_PRED},
    '{1'b0, '{OP_MUL, -32'sd6, 31'd35, 32'sd14, 31'd9}, R_PRED},
    // divide by a zero operand
    '{1'b1, '{OP_DIV, 32'sd3, 31'd4, 32'sd0, 31'd5}, R_DIV0},
    '{1'b0, '{OP_DIV, -32'sd1, 31'd2, -32'sd3, 31'd4}, R_PRED},
    // compare: less, equal after reduction, neither
    '{1'b1, '{OP_CMP, 32'sd1, 31'd3, 32'sd1, 31'd2}, R_LESS},
    '{1'b1, '{OP_CMP, 32'sd2, 31'd4, 32'sd1, 31'd2}, R_EQ},
    '{1'b1, '{OP_CMP, -32'sd1, 31'd1, -32'sd2, 31'd1}, R_ZERO},
    // zero denominator on either side, compare included
    '{1'b1, '{OP_ADD, 32'sd1, 31'd0, 32'sd1, 31'd1}, R_DIV0},
    '{1'b1, '{OP_CMP, 32'sd1, 31'd1, 32'sd1, 31'd0}, R_DIV0},
    // unused codes, the last one with a zero denominator
    '{1'b1, '{OP_RSVD5, 32'sd3, 31'd4, 32'sd5, 31'd6}, R_ZERO},
    '{1'b1, '{OP_RSVD6, MAX_NUM, MAX_DEN, MIN_NUM, 31'd1}, R_ZERO},
    '{1'b1, '{OP_RSVD7, -32'sd1, 31'd0, -32'sd1, MAX_DEN}, R_DIV0},
    // most negative numerator
    '{1'b1, '{OP_MUL, MIN_NUM, 31'd1, 32'sd1, 31'd1}, R_OVF},
    '{1'b0, '{OP_SUB, MIN_NUM, 31'd2, 32'sd1, 31'd2}, R_PRED},
    '{1'b1, '{OP_DIV, MIN_NUM, 31'd1, MIN_NUM, 31'd1}, R_ONE},
    '{1'b1, '{OP_SUB, 32'sd0, MAX_DEN, MIN_NUM, 31'd1}, R_OVF},
    // largest magnitudes and denominators
    '{1'b1, '{OP_ADD, MAX_NUM, 31'd1, MAX_NUM, 31'd1}, R_OVF},
    '{1'b0, '{OP_MUL, MAX_NUM, MAX_DEN, 32'sd5, 31'd7}, R_PRED},
    '{1'b0, '{OP_ADD, 32'sd1, MAX_DEN, 32'sd1, MAX_DEN}, R_PRED},
    '{1'b1, '{OP_MUL, 32'sd1, MAX_DEN, 32'sd1, 31'd2}, R_OVF},
    '{1'b1, '{OP_CMP, MAX_NUM, 31'd1, MIN_NUM, 31'd1}, R_ZERO}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  rau_in_if  in_if ();
  rau_out_if out_if ();

  rational_arithmetic_unit #(
    .WIDTH(MODEL_WIDTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  rat_res_t pending_results [$];
  int       n_wrong   = 0;
  int       n_checked = 0;
  int       n_cycles  = 0;
  // High while both sides run without idling.
  logic     calm = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor: exact rational arithmetic at 64 bits
  // ---------------------------------------------------------------------

  function automatic logic [63:0] euclid_gcd(logic [63:0] a, logic [63:0] b);
    while (a != 64'd0 && b != 64'd0) begin
      if (a > b) a = a % b;
      else b = b % a;
    end
    return a + b;
  endfunction

  // Bring n/d to lowest terms; zero becomes 0/1.
  function automatic void to_lowest(inout logic [63:0] n, inout logic [63:0] d);
    logic [63:0] g;
    if (n == 64'd0) begin
      d = 64'd1;
      return;
    end
    g = euclid_gcd(n, d);
    n = n / g;
    d = d / g;
  endfunction

  function automatic logic [63:0] num_mag(logic [NUM_W-1:0] v);
    logic [63:0] w;
    w = {{(64 - NUM_W){v[NUM_W-1]}}, v};
    return v[NUM_W-1] ? -w : w;
  endfunction

  function automatic rat_res_t predict_result(rat_op_t it);
    logic [63:0]        an_m, bn_m, ad, bd, rn, rd, pn, pd, qn, qd, g1, g2;
    logic signed [63:0] x, y, s;
    logic               an_neg, bn_neg, rneg, arith, less, eq;
    logic [ST_W-1:0]    st;
    rat_res_t           r;
    an_neg = it.a_num[NUM_W-1];
    bn_neg = it.b_num[NUM_W-1];
    an_m   = num_mag(it.a_num);
    bn_m   = num_mag(it.b_num);
    ad     = 64'(it.a_den);
    bd     = 64'(it.b_den);
    rn     = 64'd0;
    rd     = 64'd1;
    rneg   = 1'b0;
    arith  = 1'b0;
    less   = 1'b0;
    eq     = 1'b0;
    st     = ST_OK;
    if (ad == 64'd0 || bd == 64'd0) begin
      st = ST_DIV0;
    end else begin
      to_lowest(an_m, ad);
      to_lowest(bn_m, bd);
      if (an_m == 64'd0) an_neg = 1'b0;
      if (bn_m == 64'd0) bn_neg = 1'b0;
      // cross terms stay below 2^62
      x = an_m * bd;
      y = bn_m * ad;
      if (an_neg) x = -x;
      if (bn_neg) y = -y;
      case (it.op)
        OP_ADD, OP_SUB: begin
          s     = (it.op == OP_ADD) ? x + y : x - y;
          rneg  = s < 0;
          rn    = rneg ? -s : s;
          rd    = ad * bd;
          to_lowest(rn, rd);
          arith = 1'b1;
        end
        OP_MUL, OP_DIV: begin
          pn = an_m;
          pd = ad;
          qn = bn_m;
          qd = bd;
          if (it.op == OP_DIV) begin
            if (bn_m == 64'd0) begin
              st = ST_DIV0;
            end else begin
              qn = bd;
              qd = bn_m;
            end
          end
          if (st == ST_OK) begin
            g1 = euclid_gcd(pn, qd);
            g2 = euclid_gcd(qn, pd);
            if (g1 == 64'd0) g1 = 64'd1;
            if (g2 == 64'd0) g2 = 64'd1;
            rn    = (pn / g1) * (qn / g2);
            rd    = (pd / g2) * (qd / g1);
            to_lowest(rn, rd);
            rneg  = an_neg != bn_neg;
            arith = 1'b1;
          end
        end
        OP_CMP: begin
          less = x < y;
          eq   = x == y;
        end
        default: begin
        end
      endcase
    end
    if (arith) begin
      if (rn == 64'd0) rneg = 1'b0;
      if (rn > RES_LIM || rd > RES_LIM) st = ST_OVF;
    end
    if (st != ST_OK || !arith) begin
      rn   = 64'd0;
      rd   = 64'd1;
      rneg = 1'b0;
      if (st != ST_OK) begin
        less = 1'b0;
        eq   = 1'b0;
      end
    end
    r.res_num  = rneg ? NUM_W'(-rn) : rn[NUM_W-1:0];
    r.res_den  = rd[DEN_W-1:0];
    r.is_less  = less;
    r.is_equal = eq;
    r.status   = st;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Random operands: mostly small values so that results stay in range
  // and reduce, some full-width values and the extremes
  // ---------------------------------------------------------------------

  function automatic logic [NUM_W-1:0] rand_num();
    int unsigned      pick;
    logic [31:0]      r;
    logic [NUM_W-1:0] v;
    pick = $urandom_range(0, 99);
    r    = $urandom;
    if (pick < 40) begin
      v = NUM_W'($urandom_range(0, 40)) - NUM_W'(20);
    end else if (pick < 65) begin
      v = {{16{r[15]}}, r[15:0]};
    end else if (pick < 90) begin
      v = r;
    end else begin
      case ($urandom_range(0, 4))
        0:       v = '0;
        1:       v = NUM_W'(1);
        2:       v = '1;
        3:       v = MAX_NUM;
        default: v = MIN_NUM;
      endcase
    end
    return v;
  endfunction

  function automatic logic [DEN_W-1:0] rand_den();
    int unsigned      pick;
    logic [DEN_W-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      v = DEN_W'($urandom_range(1, 24));
    end else if (pick < 65) begin
      v = DEN_W'($urandom_range(1, 65535));
    end else if (pick < 90) begin
      v = DEN_W'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0:       v = '0;
        1:       v = DEN_W'(1);
        2:       v = MAX_DEN;
        default: v = DEN_W'(1) << $urandom_range(0, DEN_W - 1);
      endcase
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(string what);
    if (n_wrong < MAX_LINES) $display("ERROR: result %0d: %s", n_checked, what);
    n_wrong++;
  endtask

  // Present one item, hold it until the unit takes it, then record what
  // it must produce. Entered and left at a rising edge.
  task automatic send_item(rat_op_t it, rat_res_t typed_res, logic typed);
    // idle gaps before the item, none while calm
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op    <= it.op;
    in_if.a_num <= it.a_num;
    in_if.a_den <= it.a_den;
    in_if.b_num <= it.b_num;
    in_if.b_den <= it.b_den;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.insert(pending_results.size(),
                           typed ? typed_res : predict_result(it));
  endtask

  // Result side: sample at the edge, compare with the oldest expectation,
  // then pick the ready level for the next cycle.
  initial begin
    rat_res_t got, want;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got = '{out_if.res_num, out_if.res_den, out_if.is_less, out_if.is_equal,
                out_if.status};
        if (pending_results.size() == 0) begin
          report_mismatch("result with no item waiting for it");
        end else begin
          want = pending_results.pop_front();
          if (got.res_num !== want.res_num)
            report_mismatch($sformatf("res_num %0d, want %0d",
                                      $signed(got.res_num), $signed(want.res_num)));
          if (got.res_den !== want.res_den)
            report_mismatch($sformatf("res_den %0d, want %0d", got.res_den, want.res_den));
          if (got.is_less !== want.is_less)
            report_mismatch($sformatf("is_less %b, want %b", got.is_less, want.is_less));
          if (got.is_equal !== want.is_equal)
            report_mismatch($sformatf("is_equal %b, want %b", got.is_equal, want.is_equal));
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        end
        n_checked++;
      end
      out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Hard stop in case the unit hangs.
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("rational_arithmetic_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  initial begin
    rat_op_t     it;
    logic [OP_W-1:0] op;
    rst_ni      = 1'b0;
    in_if.valid = 1'b0;
    in_if.op    = OP_ADD;
    in_if.a_num = '0;
    in_if.a_den = DEN_W'(1);
    in_if.b_num = '0;
    in_if.b_den = DEN_W'(1);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: every operation, extremes and error codes
    for (int i = 0; i < N_DIRECTED; i++)
      send_item(DIRECTED[i].opnd, DIRECTED[i].res, DIRECTED[i].typed);

    // random items, with a stretch in the middle where neither side idles
    for (int i = 0; i < N_RANDOM; i++) begin
      calm <= (i >= 350 && i < 500);
      if ($urandom_range(0, 99) < 6) op = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
      else op = OP_W'($urandom_range(OP_ADD, OP_CMP));
      it = '{op, rand_num(), rand_den(), rand_num(), rand_den()};
      send_item(it, R_PRED, 1'b0);
    end
    in_if.valid <= 1'b0;
    calm        <= 1'b0;

    // drain: every result in, then DRAIN_CYCLES more for stray extras
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_wrong == 0) begin
      $display("rational_arithmetic_unit: match");
    end else begin
      $display("rational_arithmetic_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rau_pkg.sv
sv/rau_in_if.sv
sv/rau_out_if.sv
sv/rau_divmod.sv
sv/rau_mul.sv
sv/rational_arithmetic_unit.sv
sim/rational_arithmetic_unit_tb.sv
